[sv/versatile_interface_adapter_assert.svh]
// ----------------------------------------------------------------------------
// Versatile interface adapter assertion macros
// Shorthand for the clocked, reset-qualified checks used in the adapter.
// ----------------------------------------------------------------------------
`ifndef VERSATILE_INTERFACE_ADAPTER_ASSERT_SVH
`define VERSATILE_INTERFACE_ADAPTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define VIA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define VIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/via_pkg.sv]
// ----------------------------------------------------------------------------
// Versatile interface adapter package
// Beat layouts, register window map, bus opcodes and interrupt flag positions.
// ----------------------------------------------------------------------------
`default_nettype none

package via_pkg;

    // Bus access codes
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Interrupt flag bit positions (bit 7 of IFR is derived)
    localparam int FLAG_CA2 = 0;
    localparam int FLAG_CA1 = 1;
    localparam int FLAG_CB1 = 4;
    localparam int FLAG_T2  = 5;
    localparam int FLAG_T1  = 6;

    // Register window offsets
    typedef enum logic [3:0] {
        RG_PB      = 4'd0,
        RG_PA      = 4'd1,
        RG_DDB     = 4'd2,
        RG_DDA     = 4'd3,
        RG_T1CL    = 4'd4,
        RG_T1CH    = 4'd5,
        RG_T1LL    = 4'd6,
        RG_T1LH    = 4'd7,
        RG_T2L     = 4'd8,
        RG_T2H     = 4'd9,
        RG_SHF     = 4'd10,
        RG_AUX     = 4'd11,
        RG_PER     = 4'd12,
        RG_FLG     = 4'd13,
        RG_ENA     = 4'd14,
        RG_PA_NOHS = 4'd15
    } reg_idx_t;

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic       ca2_low;
        logic       cb1_valid;
        logic       cb1_level;
        logic       ca1_valid;
        logic       ca1_level;
        logic       port_b_pins_valid;
        logic [7:0] port_b_pins;
        logic       port_a_pins_valid;
        logic [7:0] port_a_pins;
        logic [7:0] data_in;
        logic [15:0] address;
    } in_beat_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        logic       irq;
        logic [7:0] port_b_dir;
        logic [7:0] port_b_value;
        logic       port_b_update;
        logic [7:0] port_a_dir;
        logic [7:0] port_a_value;
        logic       port_a_update;
        logic [7:0] read_data;
    } out_beat_t;

endpackage

`default_nettype wire

[sv/versatile_interface_adapter.sv]
// ----------------------------------------------------------------------------
// Versatile interface adapter
// Reduced peripheral interface adapter: two ports, two timers, edge-latched
// control lines and interrupt logic; one peripheral clock tick per beat.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Contents
//  input     s_tvalid s_tready s_tdata      one tick: pins, control lines, bus
//                      s_tuser              bus opcode
//  result    m_tvalid m_tready m_tdata      read data, pin updates, irq
//  config    cfg_we cfg_wdata               base address of register window
//
//  A beat enters an input register, is processed combinationally from there and
//  lands in the result register, one beat per cycle.
//  The input register frees up whenever the result register can be loaded,
//  so a full beat rate holds while m_tready stays high.
//  Reset (aresetn low, synchronous) clears all adapter state and both stage valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "versatile_interface_adapter_assert.svh"

module versatile_interface_adapter
    import via_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config: base address of register zero
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // address, data_in, port_a_pins, port_a_pins_valid, port_b_pins,
    // port_b_pins_valid, ca1_level, ca1_valid, cb1_level, cb1_valid,
    // ca2_low, zero pad
    input  wire logic [47:0] s_tdata,
    // opcode
    input  wire logic [1:0]  s_tuser,
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data, port_a_update, port_a_value, port_a_dir, port_b_update,
    // port_b_value, port_b_dir, irq, zero pad
    output logic [47:0]      m_tdata
);

    // Pipeline stages
    logic        in_valid_reg;
    in_beat_t    in_data_reg;
    logic [1:0]  in_user_reg;
    logic        out_valid_reg;
    out_beat_t   out_data_reg;
    logic        fire;

    // Adapter state
    logic [15:0] base_address_reg;
    logic [7:0]  dir_a_reg, dir_a_next;
    logic [7:0]  out_a_reg, out_a_next;
    logic [7:0]  latch_a_reg, latch_a_next;
    logic        line_ca1_reg, line_ca1_next;
    logic [7:0]  dir_b_reg, dir_b_next;
    logic [7:0]  out_b_reg, out_b_next;
    logic [7:0]  latch_b_reg, latch_b_next;
    logic        line_cb1_reg, line_cb1_next;
    logic [7:0]  irq_enable_reg, irq_enable_next;
    logic [6:0]  irq_flags_reg, irq_flags_next;
    logic [7:0]  aux_control_reg, aux_control_next;
    logic [7:0]  periph_control_reg, periph_control_next;
    logic [15:0] t1_counter_reg, t1_counter_next;
    logic [15:0] t1_reload_reg, t1_reload_next;
    logic [15:0] t2_counter_reg, t2_counter_next;
    logic [7:0]  t2_low_latch_reg, t2_low_latch_next;
    logic        pb7_level_reg, pb7_level_next;

    out_beat_t   result;

    // Handshake: process the held beat whenever the result slot frees up
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Capture input beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= in_beat_t'(s_tdata);
            in_user_reg <= s_tuser;
        end
    end

    // Hold results until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire) begin
            out_data_reg <= result;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= '0;
        end else if (cfg_we) begin
            base_address_reg <= cfg_wdata;
        end
    end

    // One tick: timers, control line edges, CA2, then bus access
    always_comb begin
        logic [7:0]  pins_a;
        logic [7:0]  pins_b;
        logic [15:0] offset;
        logic        hit;
        reg_idx_t    sel;
        logic [7:0]  d;

        dir_a_next          = dir_a_reg;
        out_a_next          = out_a_reg;
        latch_a_next        = latch_a_reg;
        line_ca1_next       = line_ca1_reg;
        dir_b_next          = dir_b_reg;
        out_b_next          = out_b_reg;
        latch_b_next        = latch_b_reg;
        line_cb1_next       = line_cb1_reg;
        irq_enable_next     = irq_enable_reg;
        irq_flags_next      = irq_flags_reg;
        aux_control_next    = aux_control_reg;
        periph_control_next = periph_control_reg;
        t1_counter_next     = t1_counter_reg;
        t1_reload_next      = t1_reload_reg;
        t2_counter_next     = t2_counter_reg;
        t2_low_latch_next   = t2_low_latch_reg;
        pb7_level_next      = pb7_level_reg;

        d = in_data_reg.data_in;
        result               = '0;
        result.read_data     = d;

        // Pin views: driven bits from the output register, the rest external
        pins_a = (out_a_reg & dir_a_reg)
               | (in_data_reg.port_a_pins_valid ? (in_data_reg.port_a_pins & ~dir_a_reg)
                                                : 8'h00);
        pins_b = (out_b_reg & dir_b_reg)
               | (in_data_reg.port_b_pins_valid ? (in_data_reg.port_b_pins & ~dir_b_reg)
                                                : 8'h00);

        // Timer 1: count down while nonzero, expire on reaching zero
        if (t1_counter_reg != 16'h0000) begin
            t1_counter_next = t1_counter_reg - 16'd1;
            if (t1_counter_reg == 16'd1) begin
                if (aux_control_reg[6]) begin
                    if (aux_control_reg[7]) begin
                        pb7_level_next = ~pb7_level_reg;
                    end
                    t1_counter_next = t1_reload_reg;
                end else if (aux_control_reg[7]) begin
                    pb7_level_next = 1'b1;
                end
                irq_flags_next[FLAG_T1] = 1'b1;
            end
        end

        // Timer 2: free-running wrap unless pulse counting is selected
        if (!aux_control_reg[5]) begin
            t2_counter_next = t2_counter_reg - 16'd1;
            if (t2_counter_reg == 16'd1) begin
                irq_flags_next[FLAG_T2] = 1'b1;
            end
        end

        // CA1 active edge: flag, and latch port A if latching is enabled
        if (in_data_reg.ca1_valid && (in_data_reg.ca1_level != line_ca1_reg)) begin
            line_ca1_next = in_data_reg.ca1_level;
            if (in_data_reg.ca1_level == periph_control_reg[0]) begin
                if (aux_control_reg[0]) begin
                    latch_a_next = pins_a;
                end
                irq_flags_next[FLAG_CA1] = 1'b1;
            end
        end

        // CB1 active edge: flag, and latch port B if latching is enabled
        if (in_data_reg.cb1_valid && (in_data_reg.cb1_level != line_cb1_reg)) begin
            line_cb1_next = in_data_reg.cb1_level;
            if (in_data_reg.cb1_level == periph_control_reg[4]) begin
                if (aux_control_reg[1]) begin
                    latch_b_next = pins_b;
                end
                irq_flags_next[FLAG_CB1] = 1'b1;
            end
        end

        if (in_data_reg.ca2_low) begin
            irq_flags_next[FLAG_CA2] = 1'b1;
        end

        // Decode the register window
        offset = in_data_reg.address - base_address_reg;
        hit    = ((in_user_reg == OP_READ) || (in_user_reg == OP_WRITE))
              && (in_data_reg.address >= base_address_reg)
              && (offset[15:4] == 12'h000);
        sel    = reg_idx_t'(offset[3:0]);

        if (hit && (in_user_reg == OP_READ)) begin
            case (sel)
                RG_PB: begin
                    result.read_data = aux_control_reg[1] ? latch_b_next : pins_b;
                end
                RG_PA, RG_PA_NOHS: begin
                    result.read_data = aux_control_reg[0] ? latch_a_next : pins_a;
                    irq_flags_next[FLAG_CA1] = 1'b0;
                end
                RG_DDB:  result.read_data = dir_b_reg;
                RG_DDA:  result.read_data = dir_a_reg;
                RG_T1CL: irq_flags_next[FLAG_T1] = 1'b0;
                RG_AUX:  result.read_data = aux_control_reg;
                RG_PER:  result.read_data = periph_control_reg;
                RG_FLG:  result.read_data = {(|irq_flags_next), irq_flags_next};
                RG_ENA:  result.read_data = irq_enable_reg | 8'h80;
                default: ;
            endcase
        end else if (hit) begin
            case (sel)
                RG_PB: begin
                    out_b_next = d;
                    if (dir_b_reg != 8'h00) begin
                        result.port_b_value  = (d & dir_b_reg) | ~dir_b_reg;
                        if (aux_control_reg[7]) begin
                            result.port_b_value[7] = pb7_level_next;
                        end
                        result.port_b_update = 1'b1;
                    end
                end
                RG_PA, RG_PA_NOHS: begin
                    out_a_next = d;
                    if (dir_a_reg != 8'h00) begin
                        result.port_a_value  = (d & dir_a_reg) | ~dir_a_reg;
                        result.port_a_update = 1'b1;
                        // Independent-interrupt CA2 modes keep their flag
                        if ((periph_control_reg[3:1] != 3'b001)
                            && (periph_control_reg[3:1] != 3'b011)) begin
                            irq_flags_next[FLAG_CA2] = 1'b0;
                        end
                    end
                    irq_flags_next[FLAG_CA1] = 1'b0;
                end
                RG_DDB: dir_b_next = d;
                RG_DDA: dir_a_next = d;
                RG_T1CL, RG_T1LL: t1_reload_next = {t1_reload_reg[15:8], d};
                RG_T1CH: begin
                    t1_reload_next  = {d, t1_reload_reg[7:0]};
                    t1_counter_next = {d, t1_reload_reg[7:0]};
                    if (aux_control_reg[7]) begin
                        pb7_level_next = 1'b0;
                    end
                    irq_flags_next[FLAG_T1] = 1'b0;
                end
                RG_T1LH: t1_reload_next = {d, t1_reload_reg[7:0]};
                RG_T2L:  t2_low_latch_next = d;
                RG_T2H: begin
                    t2_counter_next = {d, t2_low_latch_reg};
                    irq_flags_next[FLAG_T2] = 1'b0;
                end
                RG_AUX: aux_control_next = d;
                RG_PER: periph_control_next = d;
                RG_FLG: irq_flags_next = irq_flags_next & ~d[6:0];
                RG_ENA: begin
                    if (d[7]) begin
                        irq_enable_next = irq_enable_reg | d;
                    end else begin
                        irq_enable_next = irq_enable_reg & ~(d | 8'h80);
                    end
                end
                default: ;
            endcase
        end

        result.port_a_dir = dir_a_next;
        result.port_b_dir = dir_b_next;
        result.irq        = |(irq_flags_next & irq_enable_next[6:0]);
    end

    // Advance adapter state once per processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_a_reg          <= '0;
            out_a_reg          <= '0;
            latch_a_reg        <= '0;
            line_ca1_reg       <= 1'b0;
            dir_b_reg          <= '0;
            out_b_reg          <= '0;
            latch_b_reg        <= '0;
            line_cb1_reg       <= 1'b0;
            irq_enable_reg     <= '0;
            irq_flags_reg      <= '0;
            aux_control_reg    <= '0;
            periph_control_reg <= '0;
            t1_counter_reg     <= '0;
            t1_reload_reg      <= '0;
            t2_counter_reg     <= '0;
            t2_low_latch_reg   <= '0;
            pb7_level_reg      <= 1'b0;
        end else if (fire) begin
            dir_a_reg          <= dir_a_next;
            out_a_reg          <= out_a_next;
            latch_a_reg        <= latch_a_next;
            line_ca1_reg       <= line_ca1_next;
            dir_b_reg          <= dir_b_next;
            out_b_reg          <= out_b_next;
            latch_b_reg        <= latch_b_next;
            line_cb1_reg       <= line_cb1_next;
            irq_enable_reg     <= irq_enable_next;
            irq_flags_reg      <= irq_flags_next;
            aux_control_reg    <= aux_control_next;
            periph_control_reg <= periph_control_next;
            t1_counter_reg     <= t1_counter_next;
            t1_reload_reg      <= t1_reload_next;
            t2_counter_reg     <= t2_counter_next;
            t2_low_latch_reg   <= t2_low_latch_next;
            pb7_level_reg      <= pb7_level_next;
        end
    end

    // Checks
    `VIA_ASSERT_NEXT(a_fire_fills_result, aclk, aresetn, fire, out_valid_reg, "processed beat lost")
    `VIA_ASSERT_SAME(a_ready_when_free, aclk, aresetn, (!out_valid_reg || m_tready), s_tready, "input stalled with free result slot")
    `VIA_ASSERT_NEXT(a_pb7_needs_acr7, aclk, aresetn, !aux_control_reg[7], (pb7_level_reg == $past(pb7_level_reg)), "PB7 moved with timer output off")
    `VIA_ASSERT_SAME(a_update_needs_dir, aclk, aresetn, (out_valid_reg && out_data_reg.port_a_update), (out_data_reg.port_a_dir != 8'h00), "port A update with all inputs")

endmodule

`default_nettype wire
